@@ hw/rtl/hnds_pkg.sv @@
package hnds_pkg;

    // Field widths
    localparam int CW    = 32;          // coordinate, Q16.16
    localparam int UW    = 16;          // unit vector component, Q2.14
    localparam int UFRAC = UW - 2;      // fraction bits of a unit value
    localparam int DW    = 31;          // hit distance
    localparam int NVW   = 41;          // normal / light vector before normalizing

    // Normalizer datapath
    localparam int MAGW     = 30;       // magnitude after scaling into [2^29, 2^30)
    localparam int SQW      = 2 * MAGW; // one square
    localparam int XW       = 64;       // square-root remainder / root work width
    localparam int SQ_STEPS = 32;       // one root bit per stage
    localparam int LENW     = 31;       // root of a sum of three squares
    localparam int QW       = 15;       // quotient, at most 1.0 in Q2.14
    localparam int DV_STEPS = QW;       // one quotient bit per stage
    localparam int RW       = MAGW + UFRAC + 1;
    localparam int POSW     = $clog2(NVW);

    // Latencies in register stages
    localparam int FRONT_LAT = 7;
    localparam int NORM_LAT  = 5 + SQ_STEPS + DV_STEPS + 1;
    localparam int BACK_LAT  = 4;
    localparam int TOTAL_LAT = FRONT_LAT + NORM_LAT + BACK_LAT;

    typedef logic signed [NVW-1:0] nvec_t;
    typedef logic signed [UW-1:0]  unit_t;

    // Register indexes on the write port
    typedef enum logic [2:0] {
        REG_EYE_X   = 3'd0,
        REG_EYE_Y   = 3'd1,
        REG_EYE_Z   = 3'd2,
        REG_LAMP_X  = 3'd3,
        REG_LAMP_Y  = 3'd4,
        REG_LAMP_Z  = 3'd5,
        REG_GAIN    = 3'd6,
        REG_AMBIENT = 3'd7
    } reg_idx_t;

    // Shape kinds
    typedef enum logic [1:0] {
        KIND_SPHERE = 2'd0,
        KIND_CYL    = 2'd1,
        KIND_CONE   = 2'd2,
        KIND_PLANE  = 2'd3
    } kind_t;

endpackage

@@ hw/rtl/hnds_norm.sv @@
// Pipelined 3-vector normalizer: scale, squares, bit-serial root, bit-serial divide.
module hnds_norm import hnds_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  nvec_t vec [3],
    output logic  out_valid,
    output unit_t uvec [3]
);

    function automatic logic [POSW-1:0] lead_one(input logic [NVW-1:0] v);
        logic [POSW-1:0] pos;
        pos = '0;
        for (int i = 0; i < NVW; i++)
        begin
            if (v[i])
            begin
                pos = POSW'(i);
            end
        end
        return pos;
    endfunction

    // Stage A: magnitudes and their maximum
    logic            a_v_reg;
    logic [NVW-1:0]  a_mag_reg [3];
    logic [2:0]      a_sgn_reg;
    logic [NVW-1:0]  a_max_reg;
    logic [NVW-1:0]  mag_next [3];
    logic [NVW-1:0]  max_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mag_next[i] = vec[i][NVW-1] ? NVW'(-vec[i]) : NVW'(vec[i]);
        end
        max_next = mag_next[0];
        if (mag_next[1] > max_next)
        begin
            max_next = mag_next[1];
        end
        if (mag_next[2] > max_next)
        begin
            max_next = mag_next[2];
        end
    end

    // Stage B: leading-one position
    logic            b_v_reg;
    logic [NVW-1:0]  b_mag_reg [3];
    logic [2:0]      b_sgn_reg;
    logic [POSW-1:0] b_pos_reg;
    logic            b_zero_reg;

    // Stage C: common shift into [2^29, 2^30)
    logic            c_v_reg;
    logic [MAGW-1:0] c_mag_reg [3];
    logic [2:0]      c_sgn_reg;
    logic            c_zero_reg;
    logic [NVW-1:0]  sh_next [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (b_pos_reg >= POSW'(MAGW - 1))
            begin
                sh_next[i] = b_mag_reg[i] >> (b_pos_reg - POSW'(MAGW - 1));
            end
            else
            begin
                sh_next[i] = b_mag_reg[i] << (POSW'(MAGW - 1) - b_pos_reg);
            end
        end
    end

    // Stage D: squares
    logic            d_v_reg;
    logic [SQW-1:0]  d_sq_reg [3];
    logic [MAGW-1:0] d_mag_reg [3];
    logic [2:0]      d_sgn_reg;
    logic            d_zero_reg;

    // Root stages, index 0 holds the sum of squares
    logic            sq_v_reg    [0:SQ_STEPS];
    logic [XW-1:0]   sq_x_reg    [0:SQ_STEPS];
    logic [XW-1:0]   sq_r_reg    [0:SQ_STEPS];
    logic [MAGW-1:0] sq_mag_reg  [0:SQ_STEPS][3];
    logic [2:0]      sq_sgn_reg  [0:SQ_STEPS];
    logic            sq_zero_reg [0:SQ_STEPS];
    logic [XW-1:0]   sq_x_next   [0:SQ_STEPS-1];
    logic [XW-1:0]   sq_r_next   [0:SQ_STEPS-1];

    always_comb
    begin
        for (int k = 0; k < SQ_STEPS; k++)
        begin
            logic [XW-1:0] bitv;
            logic [XW-1:0] trial;
            bitv  = XW'(1) << (2 * (SQ_STEPS - 1 - k));
            trial = sq_r_reg[k] + bitv;
            if (sq_x_reg[k] >= trial)
            begin
                sq_x_next[k] = sq_x_reg[k] - trial;
                sq_r_next[k] = (sq_r_reg[k] >> 1) + bitv;
            end
            else
            begin
                sq_x_next[k] = sq_x_reg[k];
                sq_r_next[k] = sq_r_reg[k] >> 1;
            end
        end
    end

    // Divide stages, registers indexed from 1; step 0 starts from the root output
    logic            dv_v_reg    [1:DV_STEPS];
    logic [RW-1:0]   dv_rem_reg  [1:DV_STEPS][3];
    logic [QW-1:0]   dv_q_reg    [1:DV_STEPS][3];
    logic [LENW-1:0] dv_len_reg  [1:DV_STEPS];
    logic [2:0]      dv_sgn_reg  [1:DV_STEPS];
    logic            dv_zero_reg [1:DV_STEPS];
    logic [RW-1:0]   dv_rem_next [0:DV_STEPS-1][3];
    logic [QW-1:0]   dv_q_next   [0:DV_STEPS-1][3];
    logic [LENW-1:0] root_len;

    assign root_len = sq_r_reg[SQ_STEPS][LENW-1:0];

    always_comb
    begin
        for (int k = 0; k < DV_STEPS; k++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                logic [RW-1:0]   rem_src;
                logic [QW-1:0]   q_src;
                logic [LENW-1:0] len_src;
                logic [RW-1:0]   dvs;
                if (k == 0)
                begin
                    rem_src = RW'(sq_mag_reg[SQ_STEPS][i]) << UFRAC;
                    q_src   = '0;
                    len_src = root_len;
                end
                else
                begin
                    rem_src = dv_rem_reg[k][i];
                    q_src   = dv_q_reg[k][i];
                    len_src = dv_len_reg[k];
                end
                dvs = RW'(len_src) << (DV_STEPS - 1 - k);
                if (rem_src >= dvs)
                begin
                    dv_rem_next[k][i] = rem_src - dvs;
                    dv_q_next[k][i]   = q_src | (QW'(1) << (DV_STEPS - 1 - k));
                end
                else
                begin
                    dv_rem_next[k][i] = rem_src;
                    dv_q_next[k][i]   = q_src;
                end
            end
        end
    end

    // Output
    logic  out_v_reg;
    unit_t out_u_reg [3];

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg   <= 1'b0;
            b_v_reg   <= 1'b0;
            c_v_reg   <= 1'b0;
            d_v_reg   <= 1'b0;
            out_v_reg <= 1'b0;
            for (int k = 0; k <= SQ_STEPS; k++)
            begin
                sq_v_reg[k] <= 1'b0;
            end
            for (int k = 1; k <= DV_STEPS; k++)
            begin
                dv_v_reg[k] <= 1'b0;
            end
        end
        else
        begin
            a_v_reg     <= in_valid;
            b_v_reg     <= a_v_reg;
            c_v_reg     <= b_v_reg;
            d_v_reg     <= c_v_reg;
            sq_v_reg[0] <= d_v_reg;
            for (int k = 1; k <= SQ_STEPS; k++)
            begin
                sq_v_reg[k] <= sq_v_reg[k-1];
            end
            dv_v_reg[1] <= sq_v_reg[SQ_STEPS];
            for (int k = 2; k <= DV_STEPS; k++)
            begin
                dv_v_reg[k] <= dv_v_reg[k-1];
            end
            out_v_reg <= dv_v_reg[DV_STEPS];
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        a_mag_reg <= mag_next;
        a_max_reg <= max_next;
        for (int i = 0; i < 3; i++)
        begin
            a_sgn_reg[i] <= vec[i][NVW-1];
        end

        b_mag_reg  <= a_mag_reg;
        b_sgn_reg  <= a_sgn_reg;
        b_pos_reg  <= lead_one(a_max_reg);
        b_zero_reg <= (a_max_reg == '0);

        for (int i = 0; i < 3; i++)
        begin
            c_mag_reg[i] <= sh_next[i][MAGW-1:0];
        end
        c_sgn_reg  <= b_sgn_reg;
        c_zero_reg <= b_zero_reg;

        for (int i = 0; i < 3; i++)
        begin
            d_sq_reg[i] <= SQW'(c_mag_reg[i]) * SQW'(c_mag_reg[i]);
        end
        d_mag_reg  <= c_mag_reg;
        d_sgn_reg  <= c_sgn_reg;
        d_zero_reg <= c_zero_reg;

        sq_x_reg[0]    <= XW'(d_sq_reg[0]) + XW'(d_sq_reg[1]) + XW'(d_sq_reg[2]);
        sq_r_reg[0]    <= '0;
        sq_mag_reg[0]  <= d_mag_reg;
        sq_sgn_reg[0]  <= d_sgn_reg;
        sq_zero_reg[0] <= d_zero_reg;
        for (int k = 1; k <= SQ_STEPS; k++)
        begin
            sq_x_reg[k]    <= sq_x_next[k-1];
            sq_r_reg[k]    <= sq_r_next[k-1];
            sq_mag_reg[k]  <= sq_mag_reg[k-1];
            sq_sgn_reg[k]  <= sq_sgn_reg[k-1];
            sq_zero_reg[k] <= sq_zero_reg[k-1];
        end

        dv_rem_reg[1]  <= dv_rem_next[0];
        dv_q_reg[1]    <= dv_q_next[0];
        dv_len_reg[1]  <= root_len;
        dv_sgn_reg[1]  <= sq_sgn_reg[SQ_STEPS];
        dv_zero_reg[1] <= sq_zero_reg[SQ_STEPS];
        for (int k = 2; k <= DV_STEPS; k++)
        begin
            dv_rem_reg[k]  <= dv_rem_next[k-1];
            dv_q_reg[k]    <= dv_q_next[k-1];
            dv_len_reg[k]  <= dv_len_reg[k-1];
            dv_sgn_reg[k]  <= dv_sgn_reg[k-1];
            dv_zero_reg[k] <= dv_zero_reg[k-1];
        end

        // sign restore; a zero vector gives a zero unit vector
        for (int i = 0; i < 3; i++)
        begin
            if (dv_zero_reg[DV_STEPS])
            begin
                out_u_reg[i] <= '0;
            end
            else if (dv_sgn_reg[DV_STEPS][i])
            begin
                out_u_reg[i] <= -UW'(dv_q_reg[DV_STEPS][i]);
            end
            else
            begin
                out_u_reg[i] <= UW'(dv_q_reg[DV_STEPS][i]);
            end
        end
    end

    assign out_valid = out_v_reg;
    assign uvec      = out_u_reg;

endmodule

@@ hw/rtl/hit_normal_and_diffuse_shade.sv @@
// Hit point, unit surface normal and diffuse shade for one ray hit.
// Input: a hit word is taken at each rising edge with start high and busy low.
// busy is never raised, so one hit word can enter on every clock.
// Output: done is high for one cycle with hit_*, norm_*, shade and ambient_shade;
// the receiver has no way to hold it off, and none is needed.
// Seven front stages form the hit point and the raw normal (two multiplier
// levels for the axis projection), 53 stages normalize the normal and the light
// vector side by side (a one-bit-per-stage square root, then a one-bit-per-stage
// divide), and four stages form the cosine and the shade.
// Throughput: one word per cycle.
// Configuration: cfg_we writes cfg_data into register cfg_idx at a clock edge;
// write only while no hit is in flight.
// Reset: all valid bits clear, eye and lamp go to 0, gain to 1.0, ambience to 0.
module hit_normal_and_diffuse_shade import hnds_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [2:0]           cfg_idx,
    input  logic [CW-1:0]        cfg_data,
    input  logic                 start,
    output logic                 busy,
    input  logic signed [UW-1:0] dir_x,
    input  logic signed [UW-1:0] dir_y,
    input  logic signed [UW-1:0] dir_z,
    input  logic [DW-1:0]        hit_dist,
    input  logic signed [CW-1:0] obj_x,
    input  logic signed [CW-1:0] obj_y,
    input  logic signed [CW-1:0] obj_z,
    input  logic [1:0]           obj_kind,
    input  logic signed [UW-1:0] axis_x,
    input  logic signed [UW-1:0] axis_y,
    input  logic signed [UW-1:0] axis_z,
    output logic                 done,
    output logic signed [CW-1:0] hit_x,
    output logic signed [CW-1:0] hit_y,
    output logic signed [CW-1:0] hit_z,
    output logic signed [UW-1:0] norm_x,
    output logic signed [UW-1:0] norm_y,
    output logic signed [UW-1:0] norm_z,
    output logic [7:0]           shade,
    output logic [7:0]           ambient_shade
);

    localparam logic signed [UW-1:0] ONE = UW'(1 << UFRAC);

    // Configuration registers
    logic signed [CW-1:0] eye_reg  [3];
    logic signed [CW-1:0] lamp_reg [3];
    logic signed [UW-1:0] gain_reg;
    logic signed [UW-1:0] amb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                eye_reg[i]  <= '0;
                lamp_reg[i] <= '0;
            end
            gain_reg <= ONE;
            amb_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_idx))
                REG_EYE_X:   eye_reg[0]  <= cfg_data;
                REG_EYE_Y:   eye_reg[1]  <= cfg_data;
                REG_EYE_Z:   eye_reg[2]  <= cfg_data;
                REG_LAMP_X:  lamp_reg[0] <= cfg_data;
                REG_LAMP_Y:  lamp_reg[1] <= cfg_data;
                REG_LAMP_Z:  lamp_reg[2] <= cfg_data;
                REG_GAIN:    gain_reg    <= cfg_data[UW-1:0];
                REG_AMBIENT: amb_reg     <= cfg_data[UW-1:0];
                default:     ;
            endcase
        end
    end

    assign busy = 1'b0;

    logic signed [UW-1:0] dir_a  [3];
    logic signed [CW-1:0] obj_a  [3];
    logic signed [UW-1:0] axis_a [3];

    assign dir_a  = '{dir_x, dir_y, dir_z};
    assign obj_a  = '{obj_x, obj_y, obj_z};
    assign axis_a = '{axis_x, axis_y, axis_z};

    // Front pipeline registers
    logic                 s1_v_reg, s2_v_reg, s3_v_reg, s4_v_reg, s5_v_reg, s6_v_reg, s7_v_reg;
    logic signed [47:0]   s1_prod_reg [3];
    logic signed [CW-1:0] s1_obj_reg  [3];
    logic signed [UW-1:0] s1_axis_reg [3];
    logic [1:0]           s1_kind_reg;
    logic signed [CW-1:0] s2_hit_reg  [3];
    logic signed [CW-1:0] s2_obj_reg  [3];
    logic signed [UW-1:0] s2_axis_reg [3];
    logic [1:0]           s2_kind_reg;
    logic signed [CW:0]   s3_n_reg    [3];
    logic signed [CW:0]   s3_lv_reg   [3];
    logic signed [CW-1:0] s3_hit_reg  [3];
    logic signed [UW-1:0] s3_axis_reg [3];
    logic [1:0]           s3_kind_reg;
    logic signed [48:0]   s4_pr_reg   [3];
    logic signed [CW:0]   s4_n_reg    [3];
    logic signed [CW:0]   s4_lv_reg   [3];
    logic signed [CW-1:0] s4_hit_reg  [3];
    logic signed [UW-1:0] s4_axis_reg [3];
    logic [1:0]           s4_kind_reg;
    logic signed [36:0]   s5_d_reg;
    logic signed [CW:0]   s5_n_reg    [3];
    logic signed [CW:0]   s5_lv_reg   [3];
    logic signed [CW-1:0] s5_hit_reg  [3];
    logic signed [UW-1:0] s5_axis_reg [3];
    logic [1:0]           s5_kind_reg;
    logic signed [52:0]   s6_e_reg    [3];
    logic signed [CW:0]   s6_n_reg    [3];
    logic signed [CW:0]   s6_lv_reg   [3];
    logic signed [CW-1:0] s6_hit_reg  [3];
    logic signed [UW-1:0] s6_axis_reg [3];
    logic [1:0]           s6_kind_reg;
    nvec_t                s7_nn_reg   [3];
    nvec_t                s7_lv_reg   [3];
    logic signed [CW-1:0] s7_hit_reg  [3];

    // Saturated hit point
    logic signed [CW-1:0] hit_next [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            logic signed [47:0] sh;
            logic signed [33:0] sum;
            sh  = s1_prod_reg[i] >>> UFRAC;
            sum = 34'(eye_reg[i]) + sh[33:0];
            if (sum[33:31] == 3'b000 || sum[33:31] == 3'b111)
            begin
                hit_next[i] = sum[CW-1:0];
            end
            else if (sum[33])
            begin
                hit_next[i] = {1'b1, {(CW-1){1'b0}}};
            end
            else
            begin
                hit_next[i] = {1'b0, {(CW-1){1'b1}}};
            end
        end
    end

    // Projection length and raw normal by shape kind
    logic signed [50:0] dsum;
    nvec_t              nn_next [3];

    assign dsum = 51'(s4_pr_reg[0]) + 51'(s4_pr_reg[1]) + 51'(s4_pr_reg[2]);

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            logic signed [52:0] proj;
            proj = s6_e_reg[i] >>> UFRAC;
            case (kind_t'(s6_kind_reg))
                KIND_PLANE:  nn_next[i] = NVW'(s6_axis_reg[i]);
                KIND_SPHERE: nn_next[i] = NVW'(s6_n_reg[i]);
                default:     nn_next[i] = NVW'(s6_n_reg[i]) - proj[NVW-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
            s5_v_reg <= 1'b0;
            s6_v_reg <= 1'b0;
            s7_v_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg <= start && !busy;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
            s4_v_reg <= s3_v_reg;
            s5_v_reg <= s4_v_reg;
            s6_v_reg <= s5_v_reg;
            s7_v_reg <= s6_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            s1_prod_reg[i] <= 48'(dir_a[i]) * $signed(48'(hit_dist));
        end
        s1_obj_reg  <= obj_a;
        s1_axis_reg <= axis_a;
        s1_kind_reg <= obj_kind;

        s2_hit_reg  <= hit_next;
        s2_obj_reg  <= s1_obj_reg;
        s2_axis_reg <= s1_axis_reg;
        s2_kind_reg <= s1_kind_reg;

        for (int i = 0; i < 3; i++)
        begin
            s3_n_reg[i]  <= (CW+1)'(s2_hit_reg[i]) - (CW+1)'(s2_obj_reg[i]);
            s3_lv_reg[i] <= (CW+1)'(lamp_reg[i]) - (CW+1)'(s2_hit_reg[i]);
        end
        s3_hit_reg  <= s2_hit_reg;
        s3_axis_reg <= s2_axis_reg;
        s3_kind_reg <= s2_kind_reg;

        for (int i = 0; i < 3; i++)
        begin
            s4_pr_reg[i] <= 49'(s3_n_reg[i]) * 49'(s3_axis_reg[i]);
        end
        s4_n_reg    <= s3_n_reg;
        s4_lv_reg   <= s3_lv_reg;
        s4_hit_reg  <= s3_hit_reg;
        s4_axis_reg <= s3_axis_reg;
        s4_kind_reg <= s3_kind_reg;

        s5_d_reg    <= 37'(dsum >>> UFRAC);
        s5_n_reg    <= s4_n_reg;
        s5_lv_reg   <= s4_lv_reg;
        s5_hit_reg  <= s4_hit_reg;
        s5_axis_reg <= s4_axis_reg;
        s5_kind_reg <= s4_kind_reg;

        for (int i = 0; i < 3; i++)
        begin
            s6_e_reg[i] <= 53'(s5_d_reg) * 53'(s5_axis_reg[i]);
        end
        s6_n_reg    <= s5_n_reg;
        s6_lv_reg   <= s5_lv_reg;
        s6_hit_reg  <= s5_hit_reg;
        s6_axis_reg <= s5_axis_reg;
        s6_kind_reg <= s5_kind_reg;

        s7_nn_reg <= nn_next;
        for (int i = 0; i < 3; i++)
        begin
            s7_lv_reg[i] <= NVW'(s6_lv_reg[i]);
        end
        s7_hit_reg <= s6_hit_reg;
    end

    // Normalizers for the surface normal and the light direction
    logic  nu_v, lu_v;
    unit_t nu [3];
    unit_t lu [3];

    hnds_norm u_norm_n (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s7_v_reg),
        .vec       (s7_nn_reg),
        .out_valid (nu_v),
        .uvec      (nu)
    );

    hnds_norm u_norm_l (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s7_v_reg),
        .vec       (s7_lv_reg),
        .out_valid (lu_v),
        .uvec      (lu)
    );

    // Hit point rides alongside the normalizers
    logic signed [CW-1:0] hit_dly_reg [0:NORM_LAT-1][3];

    always_ff @(posedge clk)
    begin
        hit_dly_reg[0] <= s7_hit_reg;
        for (int k = 1; k < NORM_LAT; k++)
        begin
            hit_dly_reg[k] <= hit_dly_reg[k-1];
        end
    end

    // Back pipeline: dot product, cosine, gain, shade
    logic                 f1_v_reg, f2_v_reg, f3_v_reg, done_reg;
    logic signed [31:0]   f1_dp_reg  [3];
    unit_t                f1_nu_reg  [3];
    logic signed [CW-1:0] f1_hit_reg [3];
    logic [19:0]          f2_cos_reg;
    unit_t                f2_nu_reg  [3];
    logic signed [CW-1:0] f2_hit_reg [3];
    logic signed [36:0]   f3_mul_reg;
    unit_t                f3_nu_reg  [3];
    logic signed [CW-1:0] f3_hit_reg [3];
    unit_t                out_nu_reg [3];
    logic signed [CW-1:0] out_hit_reg [3];
    logic [7:0]           shade_reg;
    logic [7:0]           ashade_reg;

    logic signed [33:0]   dot_sum;
    logic [33:0]          dot_mag;
    logic signed [UW-1:0] gain_c;
    logic signed [UW-1:0] amb_c;
    logic signed [39:0]   angle;
    logic [39:0]          angle_scaled;
    logic [23:0]          amb_scaled;
    logic [7:0]           shade_next;
    logic [7:0]           ashade_next;

    assign dot_sum = 34'(f1_dp_reg[0]) + 34'(f1_dp_reg[1]) + 34'(f1_dp_reg[2]);
    assign dot_mag = dot_sum[33] ? 34'(-dot_sum) : 34'(dot_sum);
    assign gain_c  = (gain_reg > ONE) ? ONE : gain_reg;
    assign amb_c   = (amb_reg > ONE) ? ONE : amb_reg;

    always_comb
    begin
        angle = 40'(f3_mul_reg) + (40'(amb_c) <<< UFRAC);
        if (gain_reg < 0)
        begin
            angle = '0;
        end
        if (angle > 40'sd268435456)
        begin
            angle = 40'sd268435456;
        end
        angle_scaled = 40'($unsigned(angle)) * 40'd255;
        shade_next   = angle[39] ? 8'd0 : angle_scaled[2*UFRAC +: 8];
        amb_scaled   = 24'($unsigned(amb_c)) * 24'd255;
        ashade_next  = amb_c[UW-1] ? 8'd0 : amb_scaled[UFRAC +: 8];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_v_reg <= 1'b0;
            f2_v_reg <= 1'b0;
            f3_v_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            f1_v_reg <= nu_v && lu_v;
            f2_v_reg <= f1_v_reg;
            f3_v_reg <= f2_v_reg;
            done_reg <= f3_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            f1_dp_reg[i] <= 32'(lu[i]) * 32'(nu[i]);
        end
        f1_nu_reg  <= nu;
        f1_hit_reg <= hit_dly_reg[NORM_LAT-1];

        f2_cos_reg <= 20'(dot_mag >> UFRAC);
        f2_nu_reg  <= f1_nu_reg;
        f2_hit_reg <= f1_hit_reg;

        f3_mul_reg <= $signed({17'd0, f2_cos_reg}) * 37'(gain_c);
        f3_nu_reg  <= f2_nu_reg;
        f3_hit_reg <= f2_hit_reg;

        out_nu_reg  <= f3_nu_reg;
        out_hit_reg <= f3_hit_reg;
        shade_reg   <= shade_next;
        ashade_reg  <= ashade_next;
    end

    assign done          = done_reg;
    assign hit_x         = out_hit_reg[0];
    assign hit_y         = out_hit_reg[1];
    assign hit_z         = out_hit_reg[2];
    assign norm_x        = out_nu_reg[0];
    assign norm_y        = out_nu_reg[1];
    assign norm_z        = out_nu_reg[2];
    assign shade         = shade_reg;
    assign ambient_shade = ashade_reg;

    // Every result traces back to an accepted word a fixed latency earlier
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, TOTAL_LAT))
        else $error("result without matching accepted word");

    // Negative gain darkens the diffuse term entirely
    a_neg_gain: assert property (@(posedge clk) disable iff (!rst_n)
        done && $past(gain_reg[UW-1]) |-> shade == 8'd0)
        else $error("shade not zero for negative gain");

    // Negative ambience gives no ambient shade
    a_neg_amb: assert property (@(posedge clk) disable iff (!rst_n)
        done && $past(amb_reg[UW-1]) |-> ambient_shade == 8'd0)
        else $error("ambient shade not zero for negative ambience");

    // Normalized components never exceed one
    a_unit: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (norm_x <= ONE && norm_x >= -ONE && norm_y <= ONE && norm_y >= -ONE
                  && norm_z <= ONE && norm_z >= -ONE))
        else $error("normal component out of unit range");

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import hnds_pkg::*;

    // Result fields in port order
    typedef struct packed {
        logic signed [CW-1:0] hx;
        logic signed [CW-1:0] hy;
        logic signed [CW-1:0] hz;
        logic signed [UW-1:0] nx;
        logic signed [UW-1:0] ny;
        logic signed [UW-1:0] nz;
        logic [7:0]           sh;
        logic [7:0]           ash;
    } shade_word_t;

    // One hit word
    typedef struct packed {
        logic signed [UW-1:0] dx;
        logic signed [UW-1:0] dy;
        logic signed [UW-1:0] dz;
        logic [DW-1:0]        hdist;
        logic signed [CW-1:0] ox;
        logic signed [CW-1:0] oy;
        logic signed [CW-1:0] oz;
        kind_t                kind;
        logic signed [UW-1:0] ax;
        logic signed [UW-1:0] ay;
        logic signed [UW-1:0] az;
    } hit_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [2:0] cfg_idx = '0;
    logic [CW-1:0] cfg_data = '0;
    logic start = 1'b0;
    logic busy;
    hit_word_t hw_in = '0;
    logic done;
    shade_word_t got;

    // Predictor copy of the register file
    logic signed [CW-1:0] eye_r [3];
    logic signed [CW-1:0] lamp_r [3];
    logic signed [UW-1:0] gain_r;
    logic signed [UW-1:0] amb_r;

    shade_word_t shade_q [$];
    int errors = 0;

    always #1 clk = ~clk;

    hit_normal_and_diffuse_shade u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
        .start(start), .busy(busy),
        .dir_x(hw_in.dx), .dir_y(hw_in.dy), .dir_z(hw_in.dz),
        .hit_dist(hw_in.hdist),
        .obj_x(hw_in.ox), .obj_y(hw_in.oy), .obj_z(hw_in.oz),
        .obj_kind(hw_in.kind),
        .axis_x(hw_in.ax), .axis_y(hw_in.ay), .axis_z(hw_in.az),
        .done(done),
        .hit_x(got.hx), .hit_y(got.hy), .hit_z(got.hz),
        .norm_x(got.nx), .norm_y(got.ny), .norm_z(got.nz),
        .shade(got.sh), .ambient_shade(got.ash)
    );

    // Floor shift right of a signed value
    function automatic longint floor_sra(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint isqrt(longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // Unit vector in Q2.14; zero vector gives zeros and returns 0
    function automatic bit to_unit(input longint c [3], output longint u [3]);
        longint unsigned mag [3];
        longint unsigned m;
        longint unsigned sum;
        longint unsigned len;
        int rs;
        int ls;
        m = 0; sum = 0; rs = 0; ls = 0;
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = c[i] < 0 ? -c[i] : c[i];
            if (mag[i] > m) m = mag[i];
            u[i] = 0;
        end
        if (m == 0) return 0;
        while (m >= (64'd1 << 30)) begin m = m >> 1; rs++; end
        while (m < (64'd1 << 29)) begin m = m << 1; ls++; end
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = (mag[i] >> rs) << ls;
            sum += mag[i] * mag[i];
        end
        len = isqrt(sum);
        for (int i = 0; i < 3; i++)
        begin
            longint q;
            q = longint'((mag[i] << UFRAC) / len);
            u[i] = c[i] < 0 ? -q : q;
        end
        return 1;
    endfunction

    function automatic shade_word_t shade_of(hit_word_t w);
        longint dir [3], obj [3], ax [3], hit [3], n [3], nu [3], lv [3], lu [3];
        longint d, dot, cosv, g, a, one, angle, lim;
        shade_word_t r;
        dir = '{w.dx, w.dy, w.dz};
        obj = '{w.ox, w.oy, w.oz};
        ax  = '{w.ax, w.ay, w.az};
        lim = 64'sd2147483647;
        for (int i = 0; i < 3; i++)
        begin
            hit[i] = longint'(eye_r[i]) + floor_sra(dir[i] * longint'(w.hdist), UFRAC);
            if (hit[i] > lim) hit[i] = lim;
            if (hit[i] < -lim - 1) hit[i] = -lim - 1;
            n[i] = hit[i] - obj[i];
        end
        if (w.kind == KIND_PLANE)
            n = ax;
        else if (w.kind != KIND_SPHERE)
        begin
            d = floor_sra(n[0] * ax[0] + n[1] * ax[1] + n[2] * ax[2], UFRAC);
            for (int i = 0; i < 3; i++) n[i] = n[i] - floor_sra(d * ax[i], UFRAC);
        end
        void'(to_unit(n, nu));
        for (int i = 0; i < 3; i++) lv[i] = longint'(lamp_r[i]) - hit[i];
        if (to_unit(lv, lu))
        begin
            dot = lu[0] * nu[0] + lu[1] * nu[1] + lu[2] * nu[2];
            if (dot < 0) dot = -dot;
            cosv = dot >>> UFRAC;
        end
        else
            cosv = 0;
        one = 64'sd1 << UFRAC;
        g = gain_r; a = amb_r;
        if (g > one) g = one;
        if (a > one) a = one;
        angle = cosv * g + a * one;
        if (g < 0) angle = 0;
        if (angle > one * one) angle = one * one;
        r.hx = CW'(hit[0]); r.hy = CW'(hit[1]); r.hz = CW'(hit[2]);
        r.nx = UW'(nu[0]); r.ny = UW'(nu[1]); r.nz = UW'(nu[2]);
        r.sh = angle < 0 ? 8'd0 : 8'((angle * 255) >>> (2 * UFRAC));
        r.ash = a < 0 ? 8'd0 : 8'((a * 255) >>> UFRAC);
        return r;
    endfunction

    task automatic report(string what, longint g, longint e);
        errors++;
        $display("mismatch %s: got %0d expected %0d", what, g, e);
    endtask

    // Result checker
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (shade_q.size() == 0)
                report("unexpected word", 0, 0);
            else
            begin
                shade_word_t e;
                e = shade_q.pop_front();
                if (got.hx !== e.hx) report("hit_x", got.hx, e.hx);
                if (got.hy !== e.hy) report("hit_y", got.hy, e.hy);
                if (got.hz !== e.hz) report("hit_z", got.hz, e.hz);
                if (got.nx !== e.nx) report("norm_x", got.nx, e.nx);
                if (got.ny !== e.ny) report("norm_y", got.ny, e.ny);
                if (got.nz !== e.nz) report("norm_z", got.nz, e.nz);
                if (got.sh !== e.sh) report("shade", got.sh, e.sh);
                if (got.ash !== e.ash) report("ambient_shade", got.ash, e.ash);
            end
        end
    end

    // One register write; the caller lowers cfg_we after the last one
    task automatic write_reg(reg_idx_t idx, logic [CW-1:0] val);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            REG_EYE_X, REG_EYE_Y, REG_EYE_Z: eye_r[idx] = val;
            REG_LAMP_X, REG_LAMP_Y, REG_LAMP_Z: lamp_r[idx - 3] = val;
            REG_GAIN: gain_r = val[UW-1:0];
            default: amb_r = val[UW-1:0];
        endcase
    endtask

    // Drive one word; start stays high until the caller idles
    task automatic send(hit_word_t w);
        start <= 1'b1;
        hw_in <= w;
        do @(posedge clk); while (busy);
        shade_q.push_back(shade_of(w));
    endtask

    task automatic drain;
        int guard;
        guard = 0;
        start <= 1'b0;
        while (shade_q.size() != 0 && guard < 10000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (TOTAL_LAT + 8) @(posedge clk);
    endtask

    function automatic logic [UW-1:0] rand_unit();
        case ($urandom_range(0, 5))
            0: return UW'($urandom);
            1: return 16'sh4000;
            2: return 16'shC000;
            default: return UW'($urandom_range(0, 32768) - 16384);
        endcase
    endfunction

    function automatic logic [CW-1:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'h7FFF_FFFF;
            2: return 32'h8000_0000;
            default: return 32'($signed($urandom_range(0, 32'h00400000)) - 32'sh00200000);
        endcase
    endfunction

    function automatic hit_word_t rand_hit();
        hit_word_t w;
        w.dx = rand_unit(); w.dy = rand_unit(); w.dz = rand_unit();
        w.hdist = $urandom_range(0, 3) == 0 ? DW'($urandom)
                                            : DW'($urandom_range(0, 32'h00200000));
        w.ox = rand_coord(); w.oy = rand_coord(); w.oz = rand_coord();
        w.kind = kind_t'($urandom_range(0, 3));
        w.ax = rand_unit(); w.ay = rand_unit(); w.az = rand_unit();
        if ($urandom_range(0, 15) == 0) w.ax = 0;
        return w;
    endfunction

    // Directed table: hit word plus expected result where obvious
    hit_word_t dir_tab [$];
    shade_word_t dir_exp [$];
    bit dir_has [$];

    task automatic add_row(hit_word_t w, bit has, shade_word_t e);
        dir_tab.push_back(w);
        dir_has.push_back(has);
        dir_exp.push_back(e);
    endtask

    initial
    begin
        #2000000;
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        hit_word_t w;
        shade_word_t e;
        int burst;
        eye_r = '{0, 0, 0};
        lamp_r = '{0, 0, 0};
        gain_r = 16'sd16384;
        amb_r = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero everything: hit at origin, zero normal, zero light distance
        w = '0; e = '0;
        add_row(w, 1, e);
        // Plane with +1 axis on x, lamp at origin: zero light distance still
        w.kind = KIND_PLANE; w.ax = 16'sh4000;
        e.nx = 16'sh4000;
        add_row(w, 1, e);
        // Extremes: hit saturation both ways, each kind
        for (int k = 0; k < 4; k++)
        begin
            w = '0;
            w.kind = kind_t'(k);
            w.dx = 16'sh7FFF; w.dy = 16'sh8000; w.dz = 16'sh4000;
            w.hdist = '1;
            w.ox = 32'h8000_0000; w.oy = 32'h7FFF_FFFF; w.oz = 32'h1234_5678;
            w.ax = 16'sh8000; w.ay = 16'sh7FFF; w.az = 16'shFFFF;
            add_row(w, 0, e);
        end
        repeat (14) add_row(rand_hit(), 0, e);

        for (int i = 0; i < dir_tab.size(); i++)
        begin
            send(dir_tab[i]);
            if (dir_has[i] && shade_q[$] !== dir_exp[i])
                report("directed row", i, 0);
        end
        drain();

        // Phases over register settings, extremes included
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0:
                begin
                    write_reg(REG_LAMP_X, 32'h0010_0000);
                    write_reg(REG_LAMP_Y, 32'h0020_0000);
                    write_reg(REG_LAMP_Z, 32'hFFF0_0000);
                end
                1:
                begin
                    write_reg(REG_EYE_X, 32'h7FFF_FFFF);
                    write_reg(REG_EYE_Y, 32'h8000_0000);
                    write_reg(REG_EYE_Z, 32'h0001_0000);
                    write_reg(REG_GAIN, 32'h0000_7FFF);
                    write_reg(REG_AMBIENT, 32'h0000_7FFF);
                end
                2:
                begin
                    write_reg(REG_GAIN, 32'h0000_8000);
                    write_reg(REG_AMBIENT, 32'h0000_2000);
                end
                3:
                begin
                    write_reg(REG_GAIN, 32'h0000_2000);
                    write_reg(REG_AMBIENT, 32'h0000_8000);
                    write_reg(REG_LAMP_X, 32'h8000_0000);
                    write_reg(REG_LAMP_Y, 32'h7FFF_FFFF);
                end
                default:
                begin
                    write_reg(reg_idx_t'($urandom_range(0, 5)), rand_coord());
                    write_reg(REG_GAIN, $urandom_range(0, 3) == 0 ? $urandom
                                                       : $urandom_range(0, 20000));
                    write_reg(REG_AMBIENT, $urandom_range(0, 2) == 0 ? $urandom
                                                       : $urandom_range(0, 9000));
                    write_reg(REG_EYE_X, rand_coord());
                end
            endcase
            cfg_we <= 1'b0;

            // Bursts with random gaps, some long gap-free stretches
            for (int n = 0; n < 200; )
            begin
                burst = $urandom_range(1, 30);
                for (int b = 0; b < burst && n < 200; b++, n++)
                    send(rand_hit());
                if ($urandom_range(0, 3) != 0)
                begin
                    start <= 1'b0;
                    repeat ($urandom_range(1, 6)) @(posedge clk);
                end
            end
            drain();
        end

        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
